[rtl/lzhc_pkg.sv]
// Package for the LZ77 hash-chain greedy parser: sizes, codes, hash function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lzhc_pkg;
  localparam int BufDepth   = 65536;
  localparam int PosBits    = 16;
  localparam int HashBits   = 16;
  localparam int MaxDist    = 32768;
  localparam int MaxMatch   = 255;
  localparam int SymBits    = 9;
  localparam logic [31:0] HashMult = 32'h014E60CD;
  localparam logic [8:0]  Marker   = 9'd256;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  // Multiplicative hash of a 4-symbol key.
  function automatic logic [HashBits-1:0] hash_key(input logic [31:0] key);
    logic [31:0] prod;
    prod = HashMult * key;
    return prod[31 -: HashBits];
  endfunction
endpackage
`default_nettype wire

[rtl/lzhc_if.sv]
// Valid/ready channel interfaces for requests and tokens.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lzhc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [8:0] symbol;
  modport source (output valid, kind, symbol, input ready);
  modport sink (input valid, kind, symbol, output ready);
endinterface

interface lzhc_tok_if;
  logic        valid;
  logic        ready;
  logic        is_match;
  logic [8:0]  literal;
  logic [15:0] position;
  logic [15:0] distance;
  logic [7:0]  length;
  logic        done_res;
  modport source (output valid, is_match, literal, position, distance, length,
                  done_res, input ready);
  modport sink (input valid, is_match, literal, position, distance, length,
                done_res, output ready);
endinterface
`default_nettype wire

[rtl/lzhc_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lzhc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/lz77_hash_chain_greedy_parser_top.sv]
// Top level of the LZ77 hash-chain greedy parser.
// Depends on lzhc_pkg, lzhc_if and lzhc_ram.
//
// Usage: requests enter on req (kind append / token / restart, symbol).
// Append and restart give no token; a token request gives one token on tok.
// An append is taken in S_IDLE and appends may follow back to back; the
// buffer holds 65536 symbols and appends past that are dropped. Restart
// clears the chain-head table with a sweep of all 65536 heads, one head a
// cycle; after reset the same sweep runs before the first request is taken.
// A token request holds req.ready low while it runs. With the parse at the
// buffer end the block goes straight to S_FIN and loads the token there.
// Else the 4-symbol window is read in S_WIN; a window with a marker or a
// short tail gives a literal with no search. A search reads the chain head,
// then per chain candidate compares its key and, where the key matches,
// extends the match one symbol at a time (up to 251 symbols) and records
// it, so the search time depends on the data. All symbol reads share the
// single read port of the buffer.
// The token waits in an output register; the block then takes the next
// request, and a further token request waits at its end until the receiver
// has taken the previous token.
`timescale 1ns / 1ps
`default_nettype none
module lz77_hash_chain_greedy_parser_top
  import lzhc_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  lzhc_req_if.sink    req,
  lzhc_tok_if.source  tok
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WIN, S_HASH, S_HEAD, S_HEADD, S_CHK, S_CKEY,
    S_CMP, S_EXT, S_EXTJ, S_EXTK, S_CDONE, S_INS, S_ADV, S_FIN
  } state_t;

  localparam int HashDepth = 1 << HashBits;
  // chain entry: valid bit + position
  localparam int EntW = PosBits + 1;
  localparam int PW = PosBits + 1;
  localparam logic [PosBits:0] DistLim = PW'(MaxDist);
  localparam logic [7:0] LenMax = 8'(MaxMatch);

  state_t state;
  logic [PosBits:0]    fill, ppos, tail, dist_c;
  logic [PosBits:0]    j, k;
  logic [PosBits-1:0]  cpos, tpos;
  logic [HashBits-1:0] clr_addr, hsh;
  logic [2:0]          cnt;
  logic [31:0]         key, ckey;
  logic                mark, tdone;
  logic [EntW-1:0]     head_old, ent;
  logic [7:0]          len, best_len;
  logic [15:0]         best_dist;
  logic [8:0]          sym_j, lit;
  logic                accept, tok_free, ent_stop;

  // memory ports
  logic              buf_we, head_we, link_we;
  logic [PosBits-1:0] buf_waddr, buf_raddr, link_waddr, link_raddr;
  logic [8:0]        buf_wdata, buf_rdata;
  logic [HashBits-1:0] head_waddr, head_raddr;
  logic [EntW-1:0]   head_wdata, head_rdata, link_wdata, link_rdata;

  lzhc_ram #(.Width(SymBits), .Depth(BufDepth)) u_buf (
    .clk, .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_rdata));
  lzhc_ram #(.Width(EntW), .Depth(HashDepth)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  lzhc_ram #(.Width(EntW), .Depth(BufDepth)) u_link (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata));

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign tok_free = !tok.valid || tok.ready;
  assign tail = fill - ppos;
  assign dist_c = ppos - {1'b0, cpos};
  // stop the walk at an invalid, non-older or too distant entry
  assign ent_stop = !ent[EntW-1] || ({1'b0, ent[PosBits-1:0]} >= ppos) ||
                    ((ppos - {1'b0, ent[PosBits-1:0]}) > DistLim);

  // Drive memory ports from state.
  always_comb begin
    buf_we = accept && (kind_t'(req.kind) == KIND_APPEND) && !fill[PosBits];
    buf_waddr = fill[PosBits-1:0];
    buf_wdata = (req.symbol > Marker) ? Marker : req.symbol;
    head_we = (state == S_CLEAR) || (state == S_INS);
    head_waddr = (state == S_CLEAR) ? clr_addr : hsh;
    head_wdata = (state == S_CLEAR) ? '0 : {1'b1, ppos[PosBits-1:0]};
    link_we = (state == S_INS);
    link_waddr = ppos[PosBits-1:0];
    link_wdata = head_old;
    head_raddr = hsh;
    link_raddr = cpos;
    case (state)
      S_WIN:    buf_raddr = ppos[PosBits-1:0] + PosBits'(cnt[1:0]);
      S_CKEY:   buf_raddr = cpos + PosBits'(cnt[1:0]);
      S_EXT:    buf_raddr = j[PosBits-1:0];
      S_EXTJ:   buf_raddr = k[PosBits-1:0];
      default:  buf_raddr = ppos[PosBits-1:0];
    endcase
  end

  // Main sequencer: hold state and registered token outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      fill <= '0;
      ppos <= '0;
      tok.valid <= 1'b0;
      tok.is_match <= 1'b0;
      tok.literal <= '0;
      tok.position <= '0;
      tok.distance <= '0;
      tok.length <= '0;
      tok.done_res <= 1'b0;
    end else begin
      // load the token register, or drop it once taken
      if (state == S_FIN && tok_free) begin
        tok.valid <= 1'b1;
        tok.done_res <= tdone;
        tok.is_match <= !tdone && (best_len != 8'd0);
        tok.literal <= (tdone || best_len != 8'd0) ? '0 : lit;
        tok.position <= tdone ? '0 : tpos;
        tok.distance <= tdone ? '0 : best_dist;
        tok.length <= tdone ? '0 : best_len;
      end else if (tok.ready) begin
        tok.valid <= 1'b0;
      end

      case (state)
        // sweep the head table
        S_CLEAR: begin
          clr_addr <= clr_addr + HashBits'(1);
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (kind_t'(req.kind))
              KIND_APPEND: if (!fill[PosBits]) fill <= fill + PW'(1);
              KIND_RESTART: begin
                fill <= '0;
                ppos <= '0;
                clr_addr <= '0;
                state <= S_CLEAR;
              end
              KIND_REQUEST: begin
                tpos <= ppos[PosBits-1:0];
                best_len <= '0;
                best_dist <= '0;
                cnt <= '0;
                key <= '0;
                if (ppos >= fill) begin
                  tdone <= 1'b1;
                  state <= S_FIN;
                end else begin
                  tdone <= 1'b0;
                  mark <= (tail < PW'(4));
                  state <= S_WIN;
                end
              end
              default: ;
            endcase
          end
        end
        // read the four window symbols; read data arrives in the cycle after its address
        S_WIN: begin
          if (cnt != 3'd0) begin
            key <= {key[23:0], buf_rdata[7:0]};
            if (buf_rdata >= Marker) mark <= 1'b1;
          end
          if (cnt == 3'd1) lit <= buf_rdata;
          if (cnt == 3'd4) state <= S_HASH;
          else cnt <= cnt + 3'd1;
        end
        S_HASH: begin
          if (mark) state <= S_ADV;
          else begin
            hsh <= hash_key(key);
            state <= S_HEAD;
          end
        end
        // head read in flight
        S_HEAD: state <= S_HEADD;
        S_HEADD: begin
          head_old <= head_rdata;
          ent <= head_rdata;
          state <= S_CHK;
        end
        // check the current entry; stop or start the key compare
        S_CHK: begin
          if (ent_stop) state <= S_INS;
          else begin
            cpos <= ent[PosBits-1:0];
            cnt <= '0;
            ckey <= '0;
            state <= S_CKEY;
          end
        end
        S_CKEY: begin
          if (cnt != 3'd0) ckey <= {ckey[23:0], buf_rdata[7:0]};
          if (cnt == 3'd4) state <= S_CMP;
          else cnt <= cnt + 3'd1;
        end
        // key done: extend, or follow the link
        S_CMP: begin
          if (ckey == key) begin
            j <= ppos + PW'(4);
            k <= {1'b0, cpos} + PW'(4);
            len <= 8'd4;
            state <= S_EXT;
          end else begin
            ent <= link_rdata;
            state <= S_CHK;
          end
        end
        // extend: read j, then k, then compare
        S_EXT: begin
          if (j >= fill || len >= LenMax) state <= S_CDONE;
          else state <= S_EXTJ;
        end
        S_EXTJ: begin
          sym_j <= buf_rdata;
          state <= S_EXTK;
        end
        S_EXTK: begin
          if (buf_rdata == sym_j && sym_j != Marker) begin
            j <= j + PW'(1);
            k <= k + PW'(1);
            len <= len + 8'd1;
            state <= S_EXT;
          end else state <= S_CDONE;
        end
        // record the candidate, older wins a tie, then follow the link
        S_CDONE: begin
          if (len >= best_len) begin
            best_len <= len;
            best_dist <= dist_c[15:0];
          end
          ent <= link_rdata;
          state <= S_CHK;
        end
        S_INS: state <= S_ADV;
        // advance the parse position
        S_ADV: begin
          if (best_len == 8'd0) ppos <= ppos + PW'(1);
          else ppos <= ppos + PW'(best_len);
          state <= S_FIN;
        end
        S_FIN: begin
          if (tok_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !accept) else $error("request taken during clear");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= PW'(BufDepth)) else $error("fill beyond depth");
  a_parse_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ppos <= fill) else $error("parse past fill");
  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok.valid && !tok.ready |=> tok.valid && $stable(tok.position) &&
    $stable(tok.length)) else $error("token dropped while stalled");
endmodule
`default_nettype wire
